@@ sv/svms_pkg.sv @@
package svms_pkg;

  // Width of duration, step amount and wait counter
  localparam int unsigned DurBits      = 24;
  localparam int unsigned JiffiesPerMs = 56448;
  localparam int unsigned WaitResetVal = 10 * JiffiesPerMs;
  localparam logic [DurBits-1:0] WaitReset = DurBits'(WaitResetVal);

  typedef enum logic [2:0] {
    OP_MUTE    = 3'd0,
    OP_UNMUTE  = 3'd1,
    OP_AUDIO   = 3'd2,
    OP_SILENCE = 3'd3,
    OP_HALT    = 3'd4,
    OP_ATTACH  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    CMD_NONE         = 3'd0,
    CMD_SET_MUTED    = 3'd1,
    CMD_SET_UNMUTED  = 3'd2,
    CMD_BEGIN_MUTE   = 3'd3,
    CMD_BEGIN_UNMUTE = 3'd4,
    CMD_STEP_MUTE    = 3'd5,
    CMD_STEP_UNMUTE  = 3'd6
  } cmd_e;

  typedef enum logic [4:0] {
    MODE_RUNNING     = 5'b00001,
    MODE_MUTE_RAMP   = 5'b00010,
    MODE_MUTE_WAIT   = 5'b00100,
    MODE_MUTED       = 5'b01000,
    MODE_UNMUTE_RAMP = 5'b10000
  } mode_e;

  localparam logic [2:0] MODE_CODE_RUNNING     = 3'd0;
  localparam logic [2:0] MODE_CODE_MUTE_RAMP   = 3'd1;
  localparam logic [2:0] MODE_CODE_MUTE_WAIT   = 3'd2;
  localparam logic [2:0] MODE_CODE_MUTED       = 3'd3;
  localparam logic [2:0] MODE_CODE_UNMUTE_RAMP = 3'd4;

  typedef struct packed {
    mode_e              mode;
    logic               halted;
    logic               attached;
    logic [DurBits-1:0] wait_left;
  } state_t;

  typedef struct packed {
    cmd_e               cmd;
    logic [DurBits-1:0] step_amount;
    logic               release_waiter;
    logic               caller_blocks;
    logic               halt_reported;
  } res_t;

  // Map the one-hot mode onto its external code
  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    unique case (m)
      MODE_RUNNING:     c = MODE_CODE_RUNNING;
      MODE_MUTE_RAMP:   c = MODE_CODE_MUTE_RAMP;
      MODE_MUTE_WAIT:   c = MODE_CODE_MUTE_WAIT;
      MODE_MUTED:       c = MODE_CODE_MUTED;
      MODE_UNMUTE_RAMP: c = MODE_CODE_UNMUTE_RAMP;
      default:          c = MODE_CODE_RUNNING;
    endcase
    return c;
  endfunction

endpackage

@@ sv/stepped_volume_mute_sequencer.sv @@
// Stepped volume mute sequencer.
// Input channel (in_valid_i/in_ready_o) takes one item per handshake: an
// operation (mute, unmute, audio, silence, halt complete, attach ramp unit),
// its duration and the ramp unit's completion answer for that item.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per
// item: ramp command, step amount, mode after the item, and the release,
// block and halt flags.
// Configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the
// post-ramp mute wait; it is always ready. It is to be written only while
// idle, by the user: the block itself does not enforce this.
// Pipeline: input register, one pass of mode logic, result register.
// Throughput is one item per cycle while the receiver takes results, set by
// the combinational mode update against the state registers as an item
// moves from the input register to the result register.
// Reset: mode running, halted flag set, ramp unit detached, wait counter
// zero, mute wait 564480 jiffies; both stages empty.
// Receiver stall: the result register holds, the input register takes one
// more item, then in_ready_o drops until the result is taken. State only
// moves when an item advances, so stalls never change the outcome.
module stepped_volume_mute_sequencer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [svms_pkg::DurBits-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   operation_i,
  input  logic [svms_pkg::DurBits-1:0] duration_i,
  input  logic                         ramp_complete_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   ramp_command_o,
  output logic [svms_pkg::DurBits-1:0] step_amount_o,
  output logic [2:0]                   mode_now_o,
  output logic                         release_waiter_o,
  output logic                         caller_blocks_o,
  output logic                         halt_reported_o
);
  import svms_pkg::*;

  logic               item_valid;
  logic [2:0]         item_op;
  logic [DurBits-1:0] item_dur;
  logic               item_done;
  logic               advance;

  logic [DurBits-1:0] mute_wait_q;
  state_t             state_q, state_d;
  res_t               res_d, res_q;
  logic               out_valid_q, out_valid_d;

  // Config register: always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mute_wait_q <= WaitReset;
    end else if (cfg_valid_i) begin
      mute_wait_q <= cfg_data_i;
    end
  end

  // Advance the held item when the result register is free or draining
  assign advance = item_valid && (!out_valid_q || out_ready_i);

  svms_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .duration_i      (duration_i),
    .ramp_complete_i (ramp_complete_i),
    .advance_i       (advance),
    .valid_o         (item_valid),
    .operation_o     (item_op),
    .duration_o      (item_dur),
    .ramp_complete_o (item_done)
  );

  svms_step u_step (
    .state_i         (state_q),
    .operation_i     (item_op),
    .duration_i      (item_dur),
    .ramp_complete_i (item_done),
    .mute_wait_i     (mute_wait_q),
    .state_o         (state_d),
    .res_o           (res_d)
  );

  // Mode state: commit only when an item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode      <= MODE_RUNNING;
      state_q.halted    <= 1'b1;
      state_q.attached  <= 1'b0;
      state_q.wait_left <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  logic [2:0] mode_now_q;

  // Result payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q      <= res_d;
      mode_now_q <= mode_code(state_d.mode);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ramp_command_o   = res_q.cmd;
  assign step_amount_o    = res_q.step_amount;
  assign mode_now_o       = mode_now_q;
  assign release_waiter_o = res_q.release_waiter;
  assign caller_blocks_o  = res_q.caller_blocks;
  assign halt_reported_o  = res_q.halt_reported;

`ifndef ASSERT_OFF
  // A waiter is only released out of a muting mode
  a_release_from_muting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.release_waiter |->
      (state_q.mode == MODE_MUTE_RAMP || state_q.mode == MODE_MUTE_WAIT))
    else $error("waiter released outside a muting mode");

  // A blocked caller leaves the block in the muting ramp
  a_block_enters_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.caller_blocks |=> state_q.mode == MODE_MUTE_RAMP)
    else $error("caller blocked without entering muting ramp");

  // Nonzero step amount only travels with a step command
  a_amount_with_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.step_amount != '0 |->
      (res_d.cmd == CMD_STEP_MUTE || res_d.cmd == CMD_STEP_UNMUTE))
    else $error("step amount without step command");

  // State moves only when an item advances
  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an advancing item");
`endif

endmodule

@@ sv/svms_in_stage.sv @@
module svms_in_stage (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [2:0]                   operation_i,
  input  logic [svms_pkg::DurBits-1:0] duration_i,
  input  logic                         ramp_complete_i,
  input  logic                         advance_i,
  output logic                         valid_o,
  output logic [2:0]                   operation_o,
  output logic [svms_pkg::DurBits-1:0] duration_o,
  output logic                         ramp_complete_o
);
  import svms_pkg::*;

  logic               valid_q, valid_d;
  logic [2:0]         op_q;
  logic [DurBits-1:0] dur_q;
  logic               done_q;
  logic               load;

  // Free slot, or the held item leaves this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q   <= operation_i;
      dur_q  <= duration_i;
      done_q <= ramp_complete_i;
    end
  end

  assign valid_o         = valid_q;
  assign operation_o     = op_q;
  assign duration_o      = dur_q;
  assign ramp_complete_o = done_q;

endmodule

@@ sv/svms_step.sv @@
module svms_step (
  input  svms_pkg::state_t             state_i,
  input  logic [2:0]                   operation_i,
  input  logic [svms_pkg::DurBits-1:0] duration_i,
  input  logic                         ramp_complete_i,
  input  logic [svms_pkg::DurBits-1:0] mute_wait_i,
  output svms_pkg::state_t             state_o,
  output svms_pkg::res_t               res_o
);
  import svms_pkg::*;

  logic waiter;
  op_e  op;

  assign op     = op_e'(operation_i);
  assign waiter = (state_i.mode == MODE_MUTE_RAMP) || (state_i.mode == MODE_MUTE_WAIT);

  always_comb begin
    state_o = state_i;
    res_o   = '0;
    res_o.cmd = CMD_NONE;
    unique case (op)
      OP_MUTE: begin
        if (!state_i.attached) begin
          state_o.mode = MODE_MUTED;
        end else if (state_i.mode == MODE_RUNNING || state_i.mode == MODE_UNMUTE_RAMP) begin
          if (state_i.halted) begin
            state_o.mode = MODE_MUTED;
            res_o.cmd    = CMD_SET_MUTED;
          end else begin
            res_o.cmd = CMD_BEGIN_MUTE;
            if (ramp_complete_i) begin
              state_o.mode = MODE_MUTED;
            end else begin
              state_o.mode        = MODE_MUTE_RAMP;
              res_o.caller_blocks = 1'b1;
            end
          end
        end
      end
      OP_UNMUTE: begin
        if (!state_i.attached) begin
          state_o.mode = MODE_RUNNING;
        end else if (waiter || state_i.mode == MODE_MUTED) begin
          res_o.release_waiter = waiter;
          if (state_i.halted) begin
            state_o.mode = MODE_RUNNING;
            res_o.cmd    = CMD_SET_UNMUTED;
          end else begin
            res_o.cmd    = CMD_BEGIN_UNMUTE;
            state_o.mode = ramp_complete_i ? MODE_RUNNING : MODE_UNMUTE_RAMP;
          end
        end
      end
      OP_AUDIO, OP_SILENCE: begin
        // Only real audio clears the halted flag
        if (op == OP_AUDIO) begin
          state_o.halted = 1'b0;
        end
        if (state_i.mode == MODE_MUTE_RAMP) begin
          res_o.cmd         = CMD_STEP_MUTE;
          res_o.step_amount = duration_i;
          if (ramp_complete_i) begin
            state_o.mode      = MODE_MUTE_WAIT;
            state_o.wait_left = mute_wait_i;
          end
        end else if (state_i.mode == MODE_UNMUTE_RAMP) begin
          res_o.cmd         = CMD_STEP_UNMUTE;
          res_o.step_amount = duration_i;
          if (ramp_complete_i) begin
            state_o.mode = MODE_RUNNING;
          end
        end else if (state_i.mode == MODE_MUTE_WAIT) begin
          // Count the wait down, saturating at zero
          if (state_i.wait_left > duration_i) begin
            state_o.wait_left = state_i.wait_left - duration_i;
          end else begin
            state_o.wait_left    = '0;
            state_o.mode         = MODE_MUTED;
            res_o.release_waiter = 1'b1;
          end
        end
      end
      OP_HALT: begin
        state_o.halted       = 1'b1;
        state_o.wait_left    = '0;
        res_o.release_waiter = waiter;
        res_o.halt_reported  = 1'b1;
        if (waiter) begin
          state_o.mode = MODE_MUTED;
          if (state_i.attached) begin
            res_o.cmd = CMD_SET_MUTED;
          end
        end else if (state_i.mode == MODE_UNMUTE_RAMP) begin
          state_o.mode = MODE_RUNNING;
          if (state_i.attached) begin
            res_o.cmd = CMD_SET_UNMUTED;
          end
        end
      end
      OP_ATTACH: begin
        state_o.attached = 1'b1;
        if (state_i.mode == MODE_MUTED) begin
          res_o.cmd = CMD_SET_MUTED;
        end
      end
      default: begin
        // Undefined operation: no state change, empty result
      end
    endcase
  end

endmodule

@@ dv/stepped_volume_mute_sequencer_tb.sv @@
module stepped_volume_mute_sequencer_tb;
  import svms_pkg::*;

  // Operation codes that the block must ignore
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  localparam int unsigned MaxReports = 10;
  localparam int unsigned LongStallCycles = 300;

  // One result as the sequencer should return it
  typedef struct packed {
    cmd_e               cmd;
    logic [DurBits-1:0] amount;
    logic [2:0]         mode;
    logic               rel;
    logic               blocks;
    logic               halt;
  } mute_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [DurBits-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         operation_i;
  logic [DurBits-1:0] duration_i;
  logic               ramp_complete_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [2:0]         ramp_command_o;
  logic [DurBits-1:0] step_amount_o;
  logic [2:0]         mode_now_o;
  logic               release_waiter_o;
  logic               caller_blocks_o;
  logic               halt_reported_o;

  // Mirror of the sequencer state and its one register
  logic [2:0]         seq_mode;
  logic               seq_halted;
  logic               seq_attached;
  logic [DurBits-1:0] seq_wait_left;
  logic [DurBits-1:0] seq_mute_wait;

  mute_result_t pending_results[$];
  int unsigned  mismatch_count;
  int unsigned  in_idle_pct;
  int unsigned  out_stall_pct;
  int unsigned  hold_left;
  logic         long_stall_req;

  stepped_volume_mute_sequencer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .duration_i       (duration_i),
    .ramp_complete_i  (ramp_complete_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ramp_command_o   (ramp_command_o),
    .step_amount_o    (step_amount_o),
    .mode_now_o       (mode_now_o),
    .release_waiter_o (release_waiter_o),
    .caller_blocks_o  (caller_blocks_o),
    .halt_reported_o  (halt_reported_o)
  );

  always #4 clk_i = ~clk_i;

  // Advance the mirrored state by one item and return the result it causes.
  // The completion answer only matters where a begin or step goes out.
  function automatic mute_result_t step_sequencer(input logic [2:0] op,
                                                  input logic [DurBits-1:0] dur,
                                                  input logic done);
    mute_result_t r;
    logic         waiter;
    r = '0;
    // A blocked mute caller exists exactly while a mute is in progress
    waiter = (seq_mode == MODE_CODE_MUTE_RAMP) || (seq_mode == MODE_CODE_MUTE_WAIT);
    case (op)
      OP_MUTE: begin
        if (!seq_attached) begin
          // No ramp unit yet: jump straight to muted, no command
          seq_mode = MODE_CODE_MUTED;
        end else if (seq_mode == MODE_CODE_RUNNING || seq_mode == MODE_CODE_UNMUTE_RAMP) begin
          if (seq_halted) begin
            seq_mode = MODE_CODE_MUTED;
            r.cmd    = CMD_SET_MUTED;
          end else begin
            r.cmd = CMD_BEGIN_MUTE;
            if (done) begin
              seq_mode = MODE_CODE_MUTED;
            end else begin
              seq_mode = MODE_CODE_MUTE_RAMP;
              r.blocks = 1'b1;
            end
          end
        end
      end
      OP_UNMUTE: begin
        if (!seq_attached) begin
          seq_mode = MODE_CODE_RUNNING;
        end else if (seq_mode == MODE_CODE_MUTE_RAMP || seq_mode == MODE_CODE_MUTE_WAIT ||
                     seq_mode == MODE_CODE_MUTED) begin
          r.rel = waiter;
          if (seq_halted) begin
            seq_mode = MODE_CODE_RUNNING;
            r.cmd    = CMD_SET_UNMUTED;
          end else begin
            r.cmd    = CMD_BEGIN_UNMUTE;
            seq_mode = done ? MODE_CODE_RUNNING : MODE_CODE_UNMUTE_RAMP;
          end
        end
      end
      OP_AUDIO, OP_SILENCE: begin
        // Silence steps the ramps too, but only real audio clears the halt
        if (op == OP_AUDIO) seq_halted = 1'b0;
        if (seq_mode == MODE_CODE_MUTE_RAMP) begin
          r.cmd    = CMD_STEP_MUTE;
          r.amount = dur;
          if (done) begin
            seq_mode      = MODE_CODE_MUTE_WAIT;
            seq_wait_left = seq_mute_wait;
          end
        end else if (seq_mode == MODE_CODE_UNMUTE_RAMP) begin
          r.cmd    = CMD_STEP_UNMUTE;
          r.amount = dur;
          if (done) seq_mode = MODE_CODE_RUNNING;
        end else if (seq_mode == MODE_CODE_MUTE_WAIT) begin
          // Count down the post-ramp wait, saturating at zero
          if (seq_wait_left > dur) begin
            seq_wait_left = seq_wait_left - dur;
          end else begin
            seq_wait_left = '0;
            seq_mode      = MODE_CODE_MUTED;
            r.rel         = 1'b1;
          end
        end
      end
      OP_HALT: begin
        // Halt completion is always processed and always reported
        seq_halted    = 1'b1;
        seq_wait_left = '0;
        r.rel         = waiter;
        if (seq_mode == MODE_CODE_MUTE_RAMP || seq_mode == MODE_CODE_MUTE_WAIT) begin
          seq_mode = MODE_CODE_MUTED;
          if (seq_attached) r.cmd = CMD_SET_MUTED;
        end else if (seq_mode == MODE_CODE_UNMUTE_RAMP) begin
          seq_mode = MODE_CODE_RUNNING;
          if (seq_attached) r.cmd = CMD_SET_UNMUTED;
        end
        r.halt = 1'b1;
      end
      OP_ATTACH: begin
        seq_attached = 1'b1;
        if (seq_mode == MODE_CODE_MUTED) r.cmd = CMD_SET_MUTED;
      end
      default: begin
        // Unknown operation: state holds, only the mode is returned
      end
    endcase
    r.mode = seq_mode;
    return r;
  endfunction

  // Offer one item; return at the falling edge after it is accepted, with
  // valid still high so a following item can go out back to back.
  task automatic send_item(input logic [2:0] op, input logic [DurBits-1:0] dur,
                           input logic done);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    duration_i      <= dur;
    ramp_complete_i <= done;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    pending_results.push_back(step_sequencer(op, dur, done));
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every result is back and the pipeline is empty
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write the mute wait; only called with the block drained
  task automatic write_mute_wait(input logic [DurBits-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    seq_mute_wait = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    repeat (3) @(negedge clk_i);
  endtask

  // Bias the operation toward what moves the current mode forward, so most
  // traffic forms full mute/wait/unmute sequences; keep some noise.
  function automatic logic [2:0] pick_op;
    int unsigned r;
    logic [2:0]  op;
    r = $urandom_range(99);
    if (r < 2) begin
      op = (r == 0) ? OP_RSVD6 : OP_RSVD7;
    end else if (r < 4) begin
      op = OP_ATTACH;
    end else if (r < 7) begin
      op = OP_HALT;
    end else begin
      case (seq_mode)
        MODE_CODE_RUNNING:
          op = (r < 45) ? OP_MUTE : (r < 85) ? OP_AUDIO : (r < 93) ? OP_SILENCE : OP_UNMUTE;
        MODE_CODE_MUTED:
          op = (r < 45) ? OP_UNMUTE : (r < 80) ? OP_AUDIO : (r < 92) ? OP_SILENCE : OP_MUTE;
        default:
          op = (r < 70) ? OP_AUDIO : (r < 82) ? OP_SILENCE : (r < 92) ? OP_UNMUTE : OP_MUTE;
      endcase
    end
    return op;
  endfunction

  // Often fractions of the wait so a countdown spans several items
  function automatic logic [DurBits-1:0] pick_duration;
    logic [DurBits-1:0] dur;
    case ($urandom_range(9))
      0:          dur = '0;
      1:          dur = '1;
      2, 3, 4, 5: dur = (seq_mute_wait >> $urandom_range(1, 6)) + DurBits'($urandom_range(255));
      default:    dur = DurBits'($urandom);
    endcase
    return dur;
  endfunction

  task automatic run_random(input int unsigned count);
    logic [2:0] op;
    repeat (count) begin
      op = pick_op();
      send_item(op, pick_duration(), $urandom_range(99) < 30);
    end
  endtask

  // Walk every operation and special case from reset onward
  task automatic test_directed;
    send_item(OP_MUTE, DurBits'($urandom), 1'b0);        // mute before attach
    send_item(OP_UNMUTE, DurBits'($urandom), 1'b1);      // unmute before attach
    send_item(OP_RSVD6, '1, 1'b1);                       // ignored code
    send_item(OP_AUDIO, '1, 1'b1);                       // audio while running
    send_item(OP_HALT, DurBits'($urandom), 1'b0);        // halt while running
    send_item(OP_MUTE, '0, 1'b1);                        // still detached
    send_item(OP_ATTACH, DurBits'($urandom), 1'b0);      // attach while muted
    send_item(OP_UNMUTE, DurBits'($urandom), 1'b0);      // halted: set unmuted
    send_item(OP_SILENCE, '0, 1'b1);                     // silence keeps halt
    send_item(OP_MUTE, DurBits'($urandom), 1'b0);        // halted: set muted
    send_item(OP_UNMUTE, DurBits'($urandom), 1'b1);
    send_item(OP_AUDIO, '0, 1'b0);                       // clears halt
    send_item(OP_MUTE, DurBits'($urandom), 1'b1);        // ramp done at once
    send_item(OP_UNMUTE, DurBits'($urandom), 1'b0);      // into unmute ramp
    send_item(OP_SILENCE, '1, 1'b1);                     // step unmute, done
    send_item(OP_MUTE, DurBits'($urandom), 1'b0);        // caller blocks
    send_item(OP_SILENCE, '0, 1'b0);                     // step mute
    send_item(OP_AUDIO, DurBits'(1), 1'b1);              // into post-ramp wait
    send_item(OP_AUDIO, DurBits'(1), 1'b0);              // count down
    send_item(OP_UNMUTE, DurBits'($urandom), 1'b0);      // releases waiter
    send_item(OP_MUTE, DurBits'($urandom), 1'b0);        // mute during unmute ramp
    send_item(OP_HALT, DurBits'($urandom), 1'b1);        // halt in mute ramp
    send_item(OP_RSVD7, '0, 1'b0);                       // ignored code
    send_item(OP_AUDIO, DurBits'($urandom), 1'b1);
    send_item(OP_UNMUTE, DurBits'($urandom), 1'b0);
    send_item(OP_HALT, DurBits'($urandom), 1'b0);        // halt in unmute ramp
    drain();
  endtask

  // Zero, full scale, small and reset-value waits, each with its own traffic
  task automatic test_wait_extremes;
    logic [DurBits-1:0] values[4];
    values[0] = '0;
    values[1] = '1;
    values[2] = DurBits'(1);
    values[3] = DurBits'(WaitResetVal);
    foreach (values[i]) begin
      write_mute_wait(values[i]);
      run_random(60);
      drain();
    end
  endtask

  task automatic test_random_traffic(input int unsigned idle, input int unsigned stall,
                                     input int unsigned count);
    write_mute_wait(DurBits'($urandom_range(0, 2 * WaitResetVal)));
    in_idle_pct   = idle;
    out_stall_pct = stall;
    run_random(count);
    drain();
  endtask

  // Hold the receiver off long enough that both stages fill and the input
  // stalls, while the sender keeps offering items.
  task automatic test_backpressure;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    long_stall_req = 1'b1;
    run_random(60);
    drain();
  endtask

  // Receiver: random stalls, plus one long hold-off counted here
  always @(negedge clk_i) begin
    if (long_stall_req) begin
      hold_left      = LongStallCycles;
      long_stall_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left   = hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    mute_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxReports)
          $display("unexpected result: cmd=%0d amount=%0h mode=%0d rel=%0b blk=%0b halt=%0b",
                   ramp_command_o, step_amount_o, mode_now_o, release_waiter_o,
                   caller_blocks_o, halt_reported_o);
      end else begin
        want = pending_results.pop_front();
        if (ramp_command_o !== want.cmd || step_amount_o !== want.amount ||
            mode_now_o !== want.mode || release_waiter_o !== want.rel ||
            caller_blocks_o !== want.blocks || halt_reported_o !== want.halt) begin
          mismatch_count++;
          if (mismatch_count <= MaxReports) begin
            $write("mismatch at %0t (expected/actual): cmd %0d/%0d amount %0h/%0h ",
                   $realtime, want.cmd, ramp_command_o, want.amount, step_amount_o);
            $display("mode %0d/%0d rel %0b/%0b blk %0b/%0b halt %0b/%0b",
                     want.mode, mode_now_o, want.rel, release_waiter_o,
                     want.blocks, caller_blocks_o, want.halt, halt_reported_o);
          end
        end
      end
    end
  end

  initial begin
    #3200000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    operation_i     = OP_MUTE;
    duration_i      = '0;
    ramp_complete_i = 1'b0;
    out_ready_i     = 1'b0;
    mismatch_count  = 0;
    in_idle_pct     = 0;
    out_stall_pct   = 0;
    hold_left       = 0;
    long_stall_req  = 1'b0;
    // Reset state of the mirror
    seq_mode        = MODE_CODE_RUNNING;
    seq_halted      = 1'b1;
    seq_attached    = 1'b0;
    seq_wait_left   = '0;
    seq_mute_wait   = WaitReset;

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_wait_extremes();
    test_random_traffic(0, 0, 380);
    test_random_traffic(48, 0, 380);
    test_random_traffic(0, 48, 380);
    test_random_traffic(31, 31, 380);
    test_backpressure();

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ files.f @@
sv/svms_pkg.sv
sv/svms_in_stage.sv
sv/svms_step.sv
sv/stepped_volume_mute_sequencer.sv
dv/stepped_volume_mute_sequencer_tb.sv
